// ----- sv/ptd_pkg.sv -----
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared widths, codes and types for the pinned + LRU tag directory.
// ----------------------------------------------------------------------------
package ptd_pkg;

   // store depths
   localparam int PINNED_DEPTH = 256;
   localparam int LRU_DEPTH    = 512;

   localparam int PIN_AW     = (PINNED_DEPTH > 1) ? $clog2(PINNED_DEPTH) : 1;
   localparam int LRU_AW     = (LRU_DEPTH > 1) ? $clog2(LRU_DEPTH) : 1;
   localparam int PIN_FILL_W = $clog2(PINNED_DEPTH + 1);
   localparam int LRU_FILL_W = $clog2(LRU_DEPTH + 1);
   localparam int MAX_DEPTH  = (PINNED_DEPTH > LRU_DEPTH) ? PINNED_DEPTH : LRU_DEPTH;
   localparam int IDX_W      = (PIN_AW > LRU_AW) ? PIN_AW : LRU_AW;
   localparam int CNT_W      = $clog2(MAX_DEPTH + 1);

   // field widths
   localparam int FUNC_W     = 1;
   localparam int ID_W       = 32;
   localparam int STAMP_W    = 64;
   localparam int STATUS_W   = 3;
   localparam int SLOT_W     = 9;
   localparam int LRU_W      = ID_W + STAMP_W;   // {stamp, id}
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;               // slot, evicted id, zero pad

   // configuration
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;
   localparam int PIN_CAP_W  = 9;
   localparam int LRU_CAP_W  = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_PIN_CAP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LRU_CAP = 1'b1;
   localparam logic [PIN_CAP_W-1:0] PIN_CAP_RESET = 9'd50;
   localparam logic [LRU_CAP_W-1:0] LRU_CAP_RESET = 10'd16;

   // request kinds
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_PROMOTE = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_PIN_HIT    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_LRU_HIT    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FILLED     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EVICTED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_STORED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_PROMOTED   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_ALREADY    = 3'd6;
   localparam logic [STATUS_W-1:0] ST_PIN_FULL   = 3'd7;

   // scan unit control and results
   typedef struct packed {
      logic             clear;
      logic             vld;
      logic             age_en;
      logic [IDX_W-1:0] idx;
   } scan_cmd_type;

   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic              old_vld;
      logic [LRU_AW-1:0] old_idx;
      logic [ID_W-1:0]   old_id;
   } scan_res_type;

endpackage

// ----- sv/pinned_plus_lru_tag_directory_unit.sv -----
// ----------------------------------------------------------------------------
// pinned_plus_lru_tag_directory_unit
// Tag directory with a pinned id store and an LRU id/stamp store.
// ----------------------------------------------------------------------------
// Flow: a promote or a pinned hit scans only the pinned store; a lookup that
//   misses it scans the LRU store too, one entry per cycle, before the result
//   is loaded. One request at a time; the next is taken in S_IDLE, which the
//   FSM enters as the result is loaded into the output register.
// Reset (synchronous): fills and the access clock go to zero, capacities to
//   50 and 16; store RAMs are not cleared, entries past the fill are unread.
module pinned_plus_lru_tag_directory_unit import ptd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] item_id
   input  logic [FUNC_W-1:0]     req_tuser,   // [0] func
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [8:0] slot_index, [40:9] evicted_id
   output logic [STATUS_W-1:0]   rsp_tuser    // [2:0] status
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_PSCAN  = 4'b0010,
      S_LSCAN  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [PIN_CAP_W-1:0] pin_cap_ff, pin_cap_in;
   logic [LRU_CAP_W-1:0] lru_cap_ff, lru_cap_in;

   // request being worked on
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [ID_W-1:0]   id_ff, id_in;

   // scan address counter and read pipeline
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   // pinned search result, kept across the LRU pass
   logic             phit_ff, phit_in;
   logic [IDX_W-1:0] phit_idx_ff, phit_idx_in;

   // directory state
   logic [PIN_FILL_W-1:0] pin_fill_ff, pin_fill_in;
   logic [LRU_FILL_W-1:0] lru_fill_ff, lru_fill_in;
   logic [STAMP_W-1:0]    acc_clock_ff, acc_clock_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [ID_W-1:0]     rsp_evict_ff, rsp_evict_in;

   logic req_accept, out_free, load;
   logic pin_issue, lru_issue, issue, scan_done;

   logic [PIN_FILL_W-1:0] pin_cap_eff;
   logic [LRU_FILL_W-1:0] lru_cap_eff;
   logic                  pin_full, lru_room;

   logic                  pin_we;
   logic [PIN_AW-1:0]     pin_waddr;
   logic [ID_W-1:0]       pin_rdata;
   logic                  lru_we;
   logic [LRU_AW-1:0]     lru_waddr;
   logic [LRU_W-1:0]      lru_wdata;
   logic [LRU_W-1:0]      lru_rdata;

   logic [STATUS_W-1:0]   res_status;
   logic [SLOT_W-1:0]     res_slot;
   logic [ID_W-1:0]       res_evict;
   logic                  res_pin_add;
   logic                  res_lru_add;

   scan_cmd_type scan_cmd;
   scan_res_type scan_res;
   logic [ID_W-1:0] scan_id;

   // ---------------------------------------------------------------- handshakes
   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   // a finished result waits in the output register; the FSM only stalls in
   // S_FINISH when that register is still full and rsp_tready is low
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load       = (state_ff == S_FINISH) && out_free;

   // capacities saturate at the store depths
   always_comb begin
      if (int'(pin_cap_ff) > PINNED_DEPTH) begin
         pin_cap_eff = PIN_FILL_W'(PINNED_DEPTH);
      end else begin
         pin_cap_eff = PIN_FILL_W'(pin_cap_ff);
      end
      if (int'(lru_cap_ff) > LRU_DEPTH) begin
         lru_cap_eff = LRU_FILL_W'(LRU_DEPTH);
      end else begin
         lru_cap_eff = LRU_FILL_W'(lru_cap_ff);
      end
   end

   assign pin_full = (pin_fill_ff >= pin_cap_eff);
   assign lru_room = (lru_fill_ff < lru_cap_eff);

   // ---------------------------------------------------------------- scan
   // one read issued per cycle; the compare happens in the cycle after, when the
   // RAM data is out, so a pass ends once nothing is issued or in flight
   assign pin_issue = (state_ff == S_PSCAN) && (cnt_ff < CNT_W'(pin_fill_ff));
   assign lru_issue = (state_ff == S_LSCAN) && (cnt_ff < CNT_W'(lru_fill_ff));
   assign issue     = pin_issue || lru_issue;
   assign scan_done = !issue && !rd_vld_ff;

   assign scan_id = (state_ff == S_LSCAN) ? lru_rdata[ID_W-1:0] : pin_rdata;

   always_comb begin
      scan_cmd.clear  = req_accept || ((state_ff == S_PSCAN) && scan_done);
      scan_cmd.vld    = rd_vld_ff;
      scan_cmd.age_en = (state_ff == S_LSCAN);
      scan_cmd.idx    = rd_idx_ff;
   end

   ptd_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .cmd       (scan_cmd),
      .key       (id_ff),
      .ent_id    (scan_id),
      .ent_stamp (lru_rdata[LRU_W-1:ID_W]),
      .res       (scan_res)
   );

   // ---------------------------------------------------------------- stores
   ptd_ram #(.WIDTH(ID_W), .DEPTH(PINNED_DEPTH)) u_pin_ram (
      .clock (clock),
      .we    (pin_we),
      .waddr (pin_waddr),
      .wdata (id_ff),
      .raddr (cnt_ff[PIN_AW-1:0]),
      .rdata (pin_rdata)
   );

   ptd_ram #(.WIDTH(LRU_W), .DEPTH(LRU_DEPTH)) u_lru_ram (
      .clock (clock),
      .we    (lru_we),
      .waddr (lru_waddr),
      .wdata (lru_wdata),
      .raddr (cnt_ff[LRU_AW-1:0]),
      .rdata (lru_rdata)
   );

   // ---------------------------------------------------------------- decision
   // Evaluated in S_FINISH from the scan results. The stamp written is the
   // clock value before this request's advance.
   always_comb begin
      res_status  = ST_NOT_STORED;
      res_slot    = '0;
      res_evict   = '0;
      res_pin_add = 1'b0;
      res_lru_add = 1'b0;
      lru_we      = 1'b0;
      lru_waddr   = LRU_AW'(lru_fill_ff);
      if (func_ff == FUNC_PROMOTE) begin
         priority if (phit_ff) begin
            res_status = ST_ALREADY;
            res_slot   = SLOT_W'(phit_idx_ff);
         end else if (pin_full) begin
            res_status = ST_PIN_FULL;
         end else begin
            res_status  = ST_PROMOTED;
            res_slot    = SLOT_W'(pin_fill_ff);
            res_pin_add = 1'b1;
         end
      end else begin
         priority if (phit_ff) begin
            res_status = ST_PIN_HIT;
            res_slot   = SLOT_W'(phit_idx_ff);
         end else if (scan_res.hit) begin
            // refresh stamp only
            res_status = ST_LRU_HIT;
            res_slot   = SLOT_W'(scan_res.hit_idx);
            lru_we     = 1'b1;
            lru_waddr  = LRU_AW'(scan_res.hit_idx);
         end else if (lru_room) begin
            res_status  = ST_FILLED;
            res_slot    = SLOT_W'(lru_fill_ff);
            res_lru_add = 1'b1;
            lru_we      = 1'b1;
         end else if (lru_fill_ff == '0) begin
            res_status = ST_NOT_STORED;
         end else begin
            // capacity reached (or lowered below fill): replace the oldest
            res_status = ST_EVICTED;
            res_slot   = SLOT_W'(scan_res.old_idx);
            res_evict  = scan_res.old_id;
            lru_we     = 1'b1;
            lru_waddr  = scan_res.old_idx;
         end
      end
      lru_we = lru_we && load;
   end

   assign pin_we    = res_pin_add && load;
   assign pin_waddr = PIN_AW'(pin_fill_ff);
   assign lru_wdata = {acc_clock_ff, id_ff};

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      id_in        = id_ff;
      cnt_in       = cnt_ff;
      phit_in      = phit_ff;
      phit_idx_in  = phit_idx_ff;
      pin_fill_in  = pin_fill_ff;
      lru_fill_in  = lru_fill_ff;
      acc_clock_in = acc_clock_ff;
      pin_cap_in   = pin_cap_ff;
      lru_cap_in   = lru_cap_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PIN_CAP: pin_cap_in = csr_wdata[PIN_CAP_W-1:0];
            CSR_LRU_CAP: lru_cap_in = csr_wdata[LRU_CAP_W-1:0];
            default:     pin_cap_in = pin_cap_ff;
         endcase
      end

      if (issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_PSCAN;
               func_in  = req_tuser;
               id_in    = req_tdata[ID_W-1:0];
               cnt_in   = '0;
            end
         end
         S_PSCAN: begin
            if (scan_done) begin
               phit_in     = scan_res.hit;
               phit_idx_in = scan_res.hit_idx;
               cnt_in      = '0;
               if (scan_res.hit || (func_ff == FUNC_PROMOTE)) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_LSCAN;
               end
            end
         end
         S_LSCAN: begin
            if (scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
               if (res_pin_add) begin
                  pin_fill_in = pin_fill_ff + PIN_FILL_W'(1);
               end
               if (res_lru_add) begin
                  lru_fill_in = lru_fill_ff + LRU_FILL_W'(1);
               end
               // every lookup ticks; a promote only when it adds an entry
               if ((func_ff == FUNC_LOOKUP) || res_pin_add) begin
                  acc_clock_in = acc_clock_ff + STAMP_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_evict_in  = rsp_evict_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_slot_in   = res_slot;
         rsp_evict_in  = res_evict;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_vld_ff    <= 1'b0;
         phit_ff      <= 1'b0;
         pin_fill_ff  <= '0;
         lru_fill_ff  <= '0;
         acc_clock_ff <= '0;
         pin_cap_ff   <= PIN_CAP_RESET;
         lru_cap_ff   <= LRU_CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= issue;
         phit_ff      <= phit_in;
         pin_fill_ff  <= pin_fill_in;
         lru_fill_ff  <= lru_fill_in;
         acc_clock_ff <= acc_clock_in;
         pin_cap_ff   <= pin_cap_in;
         lru_cap_ff   <= lru_cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      id_ff         <= id_in;
      cnt_ff        <= cnt_in;
      rd_idx_ff     <= cnt_ff[IDX_W-1:0];
      phit_idx_ff   <= phit_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_evict_ff  <= rsp_evict_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(RSP_DATA_W - SLOT_W - ID_W)'(0), rsp_evict_ff, rsp_slot_ff};

   // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (int'(pin_fill_ff) <= PINNED_DEPTH) && (int'(lru_fill_ff) <= LRU_DEPTH))
      else $error("store fill beyond depth");

   a_evict_needs_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_EVICTED)) |-> (lru_fill_ff != '0))
      else $error("eviction reported with empty LRU store");

   a_lookup_ticks: assert property (@(posedge clock) disable iff (reset)
      (load && (func_ff == FUNC_LOOKUP)) |=>
         (acc_clock_ff == ($past(acc_clock_ff) + STAMP_W'(1))))
      else $error("lookup did not advance the access clock");

   a_no_slot_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tuser == ST_NOT_STORED) || (rsp_tuser == ST_PIN_FULL)))
         |-> (rsp_tdata == '0))
      else $error("nonzero data on a response without a slot");
`endif

endmodule

// ----- sv/ptd_ram.sv -----
// ----------------------------------------------------------------------------
// ptd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ptd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/ptd_scan.sv -----
// ----------------------------------------------------------------------------
// ptd_scan
// Per-entry compare unit: first id match and oldest stamp over one pass.
// ----------------------------------------------------------------------------
module ptd_scan import ptd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  scan_cmd_type       cmd,
   input  logic [ID_W-1:0]    key,
   input  logic [ID_W-1:0]    ent_id,
   input  logic [STAMP_W-1:0] ent_stamp,
   output scan_res_type       res
);

   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic               old_vld_ff, old_vld_in;
   logic [LRU_AW-1:0]  old_idx_ff, old_idx_in;
   logic [ID_W-1:0]    old_id_ff, old_id_in;
   logic [STAMP_W-1:0] old_stamp_ff, old_stamp_in;

   always_comb begin
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      old_vld_in   = old_vld_ff;
      old_idx_in   = old_idx_ff;
      old_id_in    = old_id_ff;
      old_stamp_in = old_stamp_ff;
      if (cmd.clear) begin
         hit_in     = 1'b0;
         old_vld_in = 1'b0;
      end else if (cmd.vld) begin
         if (!hit_ff && (ent_id == key)) begin
            hit_in     = 1'b1;
            hit_idx_in = cmd.idx;
         end
         // strict less-than: lowest index wins a tie
         if (cmd.age_en && (!old_vld_ff || (ent_stamp < old_stamp_ff))) begin
            old_vld_in   = 1'b1;
            old_idx_in   = LRU_AW'(cmd.idx);
            old_id_in    = ent_id;
            old_stamp_in = ent_stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff     <= 1'b0;
         old_vld_ff <= 1'b0;
      end else begin
         hit_ff     <= hit_in;
         old_vld_ff <= old_vld_in;
      end
      hit_idx_ff   <= hit_idx_in;
      old_idx_ff   <= old_idx_in;
      old_id_ff    <= old_id_in;
      old_stamp_ff <= old_stamp_in;
   end

   assign res.hit     = hit_ff;
   assign res.hit_idx = hit_idx_ff;
   assign res.old_vld = old_vld_ff;
   assign res.old_idx = old_idx_ff;
   assign res.old_id  = old_id_ff;

endmodule
